@@ hdl/mbet_pkg.sv @@
// shared types, constants and helpers for the mandelbrot escape-time pixel block
package mbet_pkg;

    localparam int IMAGE_WIDTH  = 1024;
    localparam int IMAGE_HEIGHT = 1024;

    localparam int COL_W       = 10;
    localparam int ROW_W       = 10;
    localparam int COORD_W     = 32;
    localparam int STEP_W      = 31;
    localparam int COUNT_W     = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROD_W      = 64;
    localparam int SUM_W       = 43;
    localparam int OFFSET_W    = COL_W + STEP_W;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_REAL_ORIGIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAG_ORIGIN     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_REAL_STEP       = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAG_STEP       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_ITERATION_LIMIT = 3'd4;

    // reset values: origin -2.5 and -2.0, pitch 1/256, limit 5000
    localparam logic signed [COORD_W-1:0] RESET_REAL_ORIGIN = -32'sd671088640;
    localparam logic signed [COORD_W-1:0] RESET_IMAG_ORIGIN = -32'sd536870912;
    localparam logic [STEP_W-1:0]         RESET_STEP        = 31'd1048576;
    localparam logic [COUNT_W-1:0]        RESET_LIMIT       = 16'd5000;

    // 4.0 in Q8.56
    localparam logic [PROD_W-1:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

    typedef struct packed {
        logic [COL_W-1:0] column;
        logic [ROW_W-1:0] row;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_W-1:0] iteration_count;
        logic               interior;
        logic [7:0]         colour_high;
        logic [7:0]         colour_low;
    } result_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] cx;
        logic signed [COORD_W-1:0] cy;
    } coord_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] real_origin;
        logic signed [COORD_W-1:0] imag_origin;
        logic [STEP_W-1:0]         real_step;
        logic [STEP_W-1:0]         imag_step;
        logic [COUNT_W-1:0]        iteration_limit;
    } cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_SAT,
        F_SNAP
    } front_state_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL,
        B_UPD,
        B_DONE
    } back_state_t;

    // clamp a wide signed value to the signed 32-bit range
    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v[SUM_W-1:COORD_W-1] == '0 || v[SUM_W-1:COORD_W-1] == '1)
        begin
            r = v[COORD_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            r = {1'b1, {(COORD_W-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

@@ hdl/mbet_front.sv @@
// front end: takes a pixel transfer and maps it to the point c
module mbet_front
    import mbet_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   pix_valid,
    output logic   pix_stall,
    input  pixel_t pix,
    input  cfg_t   cfg,
    output logic   push,
    output coord_t push_data,
    input  logic   q_full
);

    front_state_t state_reg, state_next;

    logic [COL_W-1:0]            col_reg;
    logic [ROW_W-1:0]            row_reg;
    logic [OFFSET_W-1:0]         off_re_reg;
    logic [OFFSET_W-1:0]         off_im_reg;
    logic signed [COORD_W-1:0]   cx_reg;
    logic signed [COORD_W-1:0]   cy_reg;
    logic [COORD_W:0]            cy_mag;
    logic                        snap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        push       = 1'b0;
        pix_stall  = 1'b1;
        unique case (state_reg)
            F_IDLE:
            begin
                pix_stall = 1'b0;
                if (pix_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_SAT;
            end
            F_SAT:
            begin
                state_next = F_SNAP;
            end
            F_SNAP:
            begin
                if (!q_full)
                begin
                    push       = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == F_IDLE && pix_valid)
        begin
            col_reg <= COL_W'(32'(pix.column) % IMAGE_WIDTH);
            row_reg <= ROW_W'(32'(pix.row) % IMAGE_HEIGHT);
        end
        if (state_reg == F_MUL)
        begin
            off_re_reg <= OFFSET_W'(col_reg) * OFFSET_W'(cfg.real_step);
            off_im_reg <= OFFSET_W'(row_reg) * OFFSET_W'(cfg.imag_step);
        end
        if (state_reg == F_SAT)
        begin
            cx_reg <= sat_coord(SUM_W'(cfg.real_origin) + $signed({2'b00, off_re_reg}));
            cy_reg <= sat_coord(SUM_W'(cfg.imag_origin) + $signed({2'b00, off_im_reg}));
        end
    end

    // rows within half a pitch of the axis land exactly on it
    assign cy_mag = cy_reg[COORD_W-1] ? (COORD_W+1)'(-((COORD_W+1)'(cy_reg)))
                                      : (COORD_W+1)'(cy_reg);
    assign snap   = {cy_mag, 1'b0} < {3'b000, cfg.imag_step};

    assign push_data.cx = cx_reg;
    assign push_data.cy = snap ? '0 : cy_reg;

endmodule

@@ hdl/mbet_fifo.sv @@
// short queue of mapped points between the front end and the iteration engine
module mbet_fifo
    import mbet_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  coord_t push_data,
    output logic   full,
    input  logic   pop,
    output coord_t pop_data,
    output logic   empty
);

    coord_t              mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]     fill_reg, fill_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    assign pop_data = mem[rd_ptr_reg];
    assign full     = (fill_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);

endmodule

@@ hdl/mbet_core.sv @@
// iteration engine: runs z = z*z + c and holds the finished result
module mbet_core
    import mbet_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  coord_t             q_data,
    output logic               pop,
    input  logic [COUNT_W-1:0] iteration_limit,
    output logic               res_valid,
    input  logic               res_stall,
    output result_t            res
);

    back_state_t state_reg, state_next;

    logic signed [COORD_W-1:0] cx_reg, cy_reg;
    logic signed [COORD_W-1:0] zx_reg, zy_reg;
    logic signed [PROD_W-1:0]  sq_re_reg, sq_im_reg, cross_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic                      res_valid_reg, res_valid_next;
    result_t                   res_reg;

    logic [PROD_W-1:0]         mag_sum;
    logic                      keep_going;
    logic signed [PROD_W-1:0]  diff;
    logic signed [35:0]        diff_sh;
    logic signed [36:0]        cross_sh;
    logic signed [COORD_W-1:0] zx_new, zy_new;
    logic                      load;
    logic                      interior;
    result_t                   res_next;

    // squares are nonnegative and at most 2^62, so the sum fits unsigned
    assign mag_sum    = $unsigned(sq_re_reg) + $unsigned(sq_im_reg);
    assign keep_going = (count_reg < iteration_limit) && (mag_sum < ESCAPE_BOUND);

    // arithmetic shifts take the upper bits, rounding toward minus infinity
    assign diff     = sq_re_reg - sq_im_reg;
    assign diff_sh  = diff[PROD_W-1:28];
    assign cross_sh = cross_reg[PROD_W-1:27];
    assign zx_new   = sat_coord(SUM_W'(diff_sh) + SUM_W'(cx_reg));
    assign zy_new   = sat_coord(SUM_W'(cross_sh) + SUM_W'(cy_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        load       = 1'b0;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    pop        = 1'b1;
                    state_next = B_MUL;
                end
            end
            B_MUL:
            begin
                state_next = B_UPD;
            end
            B_UPD:
            begin
                state_next = keep_going ? B_MUL : B_DONE;
            end
            B_DONE:
            begin
                // output register free or being emptied this cycle
                if (!res_valid_reg || !res_stall)
                begin
                    load       = 1'b1;
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (load)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_valid_reg && !res_stall)
        begin
            res_valid_next = 1'b0;
        end
    end

    assign interior                 = (count_reg >= iteration_limit);
    assign res_next.iteration_count = count_reg;
    assign res_next.interior        = interior;
    assign res_next.colour_high     = interior ? 8'd0 : count_reg[15:8];
    assign res_next.colour_low      = interior ? 8'd0 : count_reg[7:0];

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cx_reg    <= q_data.cx;
            cy_reg    <= q_data.cy;
            zx_reg    <= '0;
            zy_reg    <= '0;
            count_reg <= '0;
        end
        if (state_reg == B_MUL)
        begin
            sq_re_reg <= zx_reg * zx_reg;
            sq_im_reg <= zy_reg * zy_reg;
            cross_reg <= zx_reg * zy_reg;
        end
        if (state_reg == B_UPD && keep_going)
        begin
            zx_reg    <= zx_new;
            zy_reg    <= zy_new;
            count_reg <= count_reg + 1'b1;
        end
        if (load)
        begin
            res_reg <= res_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res       = res_reg;

endmodule

@@ hdl/mandelbrot_escape_time_pixel.sv @@
// top level of the mandelbrot escape-time pixel evaluator
//
// Each pixel transfer (column, row) is mapped to c = origin + index * pitch in
// signed Q4.28, then z = z*z + c is iterated from zero until |z|^2 reaches 4 or
// the iteration limit is hit; one result transfer follows for every pixel. The
// front end maps each pixel through its multiply, saturate and snap states and
// hands points on through a two-entry queue, so it takes the next pixel while
// the engine still works. Each engine iteration registers the squares and cross
// product, then does the escape test and z update; sustained throughput is set
// by that loop, with an iteration limit of 5000 by default. The result register
// lets the engine start the next point while a result waits on res_stall.
// Configuration writes take effect at once and belong in idle periods.
module mandelbrot_escape_time_pixel
    import mbet_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   pix_valid,
    output logic                   pix_stall,
    input  pixel_t                 pix,
    output logic                   res_valid,
    input  logic                   res_stall,
    output result_t                res,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t   cfg_reg, cfg_next;
    logic   push, q_full, pop, q_empty;
    coord_t push_data, pop_data;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_REAL_ORIGIN:     cfg_next.real_origin     = $signed(cfg_data);
                REG_IMAG_ORIGIN:     cfg_next.imag_origin     = $signed(cfg_data);
                REG_REAL_STEP:       cfg_next.real_step       = cfg_data[STEP_W-1:0];
                REG_IMAG_STEP:       cfg_next.imag_step       = cfg_data[STEP_W-1:0];
                REG_ITERATION_LIMIT: cfg_next.iteration_limit = cfg_data[COUNT_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.real_origin     <= RESET_REAL_ORIGIN;
            cfg_reg.imag_origin     <= RESET_IMAG_ORIGIN;
            cfg_reg.real_step       <= RESET_STEP;
            cfg_reg.imag_step       <= RESET_STEP;
            cfg_reg.iteration_limit <= RESET_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    mbet_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .pix       (pix),
        .cfg       (cfg_reg),
        .push      (push),
        .push_data (push_data),
        .q_full    (q_full)
    );

    mbet_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .pop_data  (pop_data),
        .empty     (q_empty)
    );

    mbet_core u_core (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_empty         (q_empty),
        .q_data          (pop_data),
        .pop             (pop),
        .iteration_limit (cfg_reg.iteration_limit),
        .res_valid       (res_valid),
        .res_stall       (res_stall),
        .res             (res)
    );

endmodule

@@ hdl/mbet_checker.sv @@
// port-level checks on the pixel evaluator, bound to the top level
module mbet_checker
    import mbet_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   res_valid,
    input logic                   res_stall,
    input result_t                res,
    input logic                   cfg_we,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [COUNT_W-1:0] limit_reg;

    // shadow of the iteration limit as seen on the write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= RESET_LIMIT;
        end
        else if (cfg_we && cfg_index == REG_ITERATION_LIMIT)
        begin
            limit_reg <= cfg_data[COUNT_W-1:0];
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("result changed or dropped while stalled");

    a_interior_black: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.interior |-> res.colour_high == 8'd0 && res.colour_low == 8'd0)
        else $error("interior point with nonzero colour");

    a_colour_count: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.interior |-> {res.colour_high, res.colour_low} == res.iteration_count)
        else $error("colour bytes do not match the count");

    a_interior_limit: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.interior |-> res.iteration_count == limit_reg)
        else $error("interior count differs from the limit");

    a_escape_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res.interior |-> res.iteration_count != '0
                                       && res.iteration_count < limit_reg)
        else $error("escaped count out of range");

endmodule

bind mandelbrot_escape_time_pixel mbet_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
);
